FILE: rtl/core/fba_pkg.sv
// Shared types, constants and saturation helpers of the fused bias and activation block.
package fba_pkg;

    localparam int MAX_CHANNELS_DEF = 1024;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int IDX_W  = 10;
    localparam int LEN_W  = 21;
    localparam int POS_W  = 20;
    localparam logic [LEN_W-1:0] LEN_MAX = 21'd1048576;

    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_RELU  = 3'd1;
    localparam logic [2:0] MODE_RELU6 = 3'd2;
    localparam logic [2:0] MODE_LEAKY = 3'd3;
    localparam logic [2:0] MODE_HSWISH = 3'd4;

    localparam logic [2:0] REG_ACT_MODE  = 3'd0;
    localparam logic [2:0] REG_BIAS_EN   = 3'd1;
    localparam logic [2:0] REG_CH_LEN    = 3'd2;
    localparam logic [2:0] REG_RELU6     = 3'd3;
    localparam logic [2:0] REG_SLOPE     = 3'd4;
    localparam logic [2:0] REG_INV_SCALE = 3'd5;
    localparam logic [2:0] REG_THRESHOLD = 3'd6;
    localparam logic [2:0] REG_OFFSET    = 3'd7;

    typedef struct packed {
        logic [2:0]        act_mode;
        logic              bias_enable;
        logic [LEN_W-1:0]  channel_length;
        logic [30:0]       relu6_clip;
        logic signed [31:0] leaky_slope;
        logic signed [31:0] hs_inv_scale;
        logic signed [31:0] hs_threshold;
        logic signed [31:0] hs_offset;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic ld_q;
        logic ld_wr;
        logic bias;
        logic mul1;
        logic rnd;
        logic mul2;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -33'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/fused_bias_activation_top.sv
// Top level of the fused bias-add and activation block.
// The block takes one item at a time. A bias load passes through the quotient and write
// states. A sample passes through the bias and output states with no activation, ReLU or
// ReLU6; leaky ReLU adds a multiply state, and hard-swish adds a multiply, a rounding and
// a second multiply state on the single 32x32 multiplier. The output state waits until the
// output register is free. The bias table is read through a register. The input is stalled
// while an item is in progress; a finished result waits in the output register while the
// next item is accepted. The bias table has no reset and must be loaded before bias
// addition is enabled. Values are signed fixed point with FRAC_BITS fraction bits,
// products round half up, and every result saturates to 32 bits.
module fused_bias_activation_top #(
    parameter int MAX_CHANNELS = fba_pkg::MAX_CHANNELS_DEF,
    parameter int FRAC_BITS    = fba_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic [fba_pkg::IDX_W-1:0]  i_bias_index,
    input  logic signed [31:0]         i_sample_value,
    input  logic                       i_final_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [31:0]         o_result_value,
    output logic                       o_final_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [4:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    fba_pkg::t_cfg cfg;
    fba_pkg::t_cmd cmd;
    fba_pkg::t_sts sts;

    fba_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_act_mode (cfg.act_mode),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    fba_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_bias_index   (i_bias_index),
        .i_sample_value (i_sample_value),
        .i_final_sample (i_final_sample),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_result_value (o_result_value),
        .o_final_result (o_final_result)
    );

endmodule

FILE: rtl/core/fba_regs.sv
// Configuration register file with an APB-style access port.
module fba_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output fba_pkg::t_cfg       o_cfg
);

    fba_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.act_mode       <= fba_pkg::MODE_NONE;
            r_cfg.bias_enable    <= 1'b0;
            r_cfg.channel_length <= 21'd1;
            r_cfg.relu6_clip     <= 31'd393216;
            r_cfg.leaky_slope    <= 32'sd655;
            r_cfg.hs_inv_scale   <= 32'sd10923;
            r_cfg.hs_threshold   <= 32'sd393216;
            r_cfg.hs_offset      <= 32'sd196608;
        end else if (wr_en) begin
            unique case (reg_idx)
                fba_pkg::REG_ACT_MODE:  r_cfg.act_mode       <= pwdata[2:0];
                fba_pkg::REG_BIAS_EN:   r_cfg.bias_enable    <= pwdata[0];
                fba_pkg::REG_CH_LEN:    r_cfg.channel_length <= pwdata[20:0];
                fba_pkg::REG_RELU6:     r_cfg.relu6_clip     <= pwdata[30:0];
                fba_pkg::REG_SLOPE:     r_cfg.leaky_slope    <= pwdata;
                fba_pkg::REG_INV_SCALE: r_cfg.hs_inv_scale   <= pwdata;
                fba_pkg::REG_THRESHOLD: r_cfg.hs_threshold   <= pwdata;
                fba_pkg::REG_OFFSET:    r_cfg.hs_offset      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            fba_pkg::REG_ACT_MODE:  prdata = {29'd0, r_cfg.act_mode};
            fba_pkg::REG_BIAS_EN:   prdata = {31'd0, r_cfg.bias_enable};
            fba_pkg::REG_CH_LEN:    prdata = {11'd0, r_cfg.channel_length};
            fba_pkg::REG_RELU6:     prdata = {1'b0, r_cfg.relu6_clip};
            fba_pkg::REG_SLOPE:     prdata = r_cfg.leaky_slope;
            fba_pkg::REG_INV_SCALE: prdata = r_cfg.hs_inv_scale;
            fba_pkg::REG_THRESHOLD: prdata = r_cfg.hs_threshold;
            fba_pkg::REG_OFFSET:    prdata = r_cfg.hs_offset;
            default:                prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/core/fba_ctrl.sv
// Controller state machine that sequences table loads and sample processing.
module fba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_action,
    input  logic [2:0]    i_act_mode,
    input  fba_pkg::t_sts i_sts,
    output fba_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LDQ  = 3'd1;
    localparam logic [2:0] S_LDW  = 3'd2;
    localparam logic [2:0] S_BIAS = 3'd3;
    localparam logic [2:0] S_MUL1 = 3'd4;
    localparam logic [2:0] S_RND  = 3'd5;
    localparam logic [2:0] S_MUL2 = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       is_leaky;
    logic       is_hswish;

    assign is_leaky   = (i_act_mode == fba_pkg::MODE_LEAKY);
    assign is_hswish  = (i_act_mode == fba_pkg::MODE_HSWISH);
    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_action ? S_BIAS : S_LDQ;
                end
            end
            S_LDQ: begin
                o_cmd.ld_q = 1'b1;
                n_state    = S_LDW;
            end
            S_LDW: begin
                o_cmd.ld_wr = 1'b1;
                n_state     = S_IDLE;
            end
            S_BIAS: begin
                o_cmd.bias = 1'b1;
                n_state    = (is_leaky || is_hswish) ? S_MUL1 : S_OUT;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = is_hswish ? S_RND : S_OUT;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: rtl/core/fba_dp.sv
// Datapath with the bias table, shared multiplier, activation logic, counters and output register.
module fba_dp #(
    parameter int MAX_CHANNELS = fba_pkg::MAX_CHANNELS_DEF,
    parameter int FRAC_BITS    = fba_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fba_pkg::t_cfg              i_cfg,
    input  fba_pkg::t_cmd              i_cmd,
    output fba_pkg::t_sts              o_sts,
    input  logic [fba_pkg::IDX_W-1:0]  i_bias_index,
    input  logic signed [31:0]         i_sample_value,
    input  logic                       i_final_sample,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic signed [31:0]         o_result_value,
    output logic                       o_final_result
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam bit NEED_WRAP = (MAX_CHANNELS < (1 << fba_pkg::IDX_W));
    localparam logic [20:0] RECIP =
        NEED_WRAP ? 21'(((1 << 20) + MAX_CHANNELS - 1) / MAX_CHANNELS) : 21'd0;
    localparam logic [19:0] MAX_CH_V = 20'(MAX_CHANNELS);
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(MAX_CHANNELS - 1);
    localparam logic signed [64:0] HALF   = 65'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
    localparam logic signed [64:0] SAT_LO = -65'sd2147483648;

    function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
        logic signed [64:0] pr;
        logic signed [64:0] sh;
        logic signed [31:0] r;
        pr = 65'(p) + HALF;
        sh = pr >>> FRAC_BITS;
        if (sh > SAT_HI) begin
            r = 32'sh7FFFFFFF;
        end else if (sh < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = sh[31:0];
        end
        return r;
    endfunction

    logic signed [31:0]          r_mem [MAX_CHANNELS];
    logic signed [31:0]          r_rdata;
    logic signed [31:0]          r_x;
    logic [fba_pkg::IDX_W-1:0]   r_idx;
    logic [fba_pkg::IDX_W-1:0]   r_q;
    logic                        r_final;
    logic signed [31:0]          r_c;
    logic signed [31:0]          r_m;
    logic signed [63:0]          r_prod;
    logic [fba_pkg::POS_W-1:0]   r_pos;
    logic [CH_W-1:0]             r_chan;
    logic                        r_out_valid;
    logic signed [31:0]          r_out_value;
    logic                        r_out_final;

    logic [30:0]                 q_prod;
    logic [19:0]                 qm;
    logic [fba_pkg::IDX_W-1:0]   rem;
    logic [CH_W-1:0]             wr_addr;
    logic signed [31:0]          mul_a;
    logic signed [31:0]          mul_b;
    logic signed [63:0]          mul_p;
    logic signed [32:0]          hs_sum;
    logic signed [31:0]          hs_c;
    logic signed [31:0]          clip32;
    logic signed [31:0]          act_val;
    logic [fba_pkg::LEN_W-1:0]   len_eff;
    logic [fba_pkg::LEN_W-1:0]   pos_inc;

    assign q_prod  = 31'(r_idx) * 31'(RECIP);
    assign qm      = 20'(r_q) * MAX_CH_V;
    assign rem     = r_idx - qm[fba_pkg::IDX_W-1:0];
    assign wr_addr = NEED_WRAP ? CH_W'(rem) : CH_W'(r_idx);

    assign mul_a = i_cmd.mul2 ? r_c : r_x;
    assign mul_b = i_cmd.mul2 ? r_m :
                   ((i_cfg.act_mode == fba_pkg::MODE_LEAKY) ? i_cfg.leaky_slope
                                                            : i_cfg.hs_inv_scale);
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign hs_sum = 33'(r_x) + 33'(i_cfg.hs_offset);
    always_comb begin
        if ((hs_sum > 33'(i_cfg.hs_threshold)) ||
            ((hs_sum < 33'sd0) && (i_cfg.hs_threshold < 32'sd0))) begin
            hs_c = i_cfg.hs_threshold;
        end else if (hs_sum < 33'sd0) begin
            hs_c = 32'sd0;
        end else begin
            hs_c = hs_sum[31:0];
        end
    end

    assign clip32 = $signed({1'b0, i_cfg.relu6_clip});

    always_comb begin
        unique case (i_cfg.act_mode)
            fba_pkg::MODE_RELU:   act_val = (r_x < 32'sd0) ? 32'sd0 : r_x;
            fba_pkg::MODE_RELU6: begin
                if (r_x < 32'sd0) begin
                    act_val = 32'sd0;
                end else if (r_x > clip32) begin
                    act_val = clip32;
                end else begin
                    act_val = r_x;
                end
            end
            fba_pkg::MODE_LEAKY:  act_val = (r_x <= 32'sd0) ? round_sat(r_prod) : r_x;
            fba_pkg::MODE_HSWISH: act_val = round_sat(r_prod);
            default:              act_val = r_x;
        endcase
    end

    always_comb begin
        if (i_cfg.channel_length == '0) begin
            len_eff = 21'd1;
        end else if (i_cfg.channel_length > fba_pkg::LEN_MAX) begin
            len_eff = fba_pkg::LEN_MAX;
        end else begin
            len_eff = i_cfg.channel_length;
        end
    end

    assign pos_inc = 21'(r_pos) + 21'd1;

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_final_result = r_out_final;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_wr) begin
            r_mem[wr_addr] <= r_x;
        end
        r_rdata <= r_mem[r_chan];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x     <= i_sample_value;
            r_idx   <= i_bias_index;
            r_final <= i_final_sample;
        end
        if (i_cmd.ld_q) begin
            r_q <= q_prod[29:20];
        end
        if (i_cmd.bias && i_cfg.bias_enable) begin
            r_x <= fba_pkg::sat33(33'(r_x) + 33'(r_rdata));
        end
        if (i_cmd.mul1) begin
            r_c <= hs_c;
        end
        if (i_cmd.mul1 || i_cmd.mul2) begin
            r_prod <= mul_p;
        end
        if (i_cmd.rnd) begin
            r_m <= round_sat(r_prod);
        end
        if (i_cmd.emit) begin
            r_out_value <= act_val;
            r_out_final <= r_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_chan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit) begin
                if (r_final) begin
                    r_pos  <= '0;
                    r_chan <= '0;
                end else if (pos_inc >= len_eff) begin
                    r_pos  <= '0;
                    r_chan <= (r_chan == LAST_CH) ? '0 : r_chan + 1'b1;
                end else begin
                    r_pos <= pos_inc[fba_pkg::POS_W-1:0];
                end
            end
        end
    end

endmodule

FILE: rtl/core/fba_checker.sv
// Port-level assertion checker for the fused bias and activation block, with its bind.
module fba_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_action,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_result_value,
    input logic        o_final_result
);

    // Every item keeps the input stalled after it is taken, through its first state and the state after it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall ##1 o_in_stall)
        else $error("input accepted again too soon after an item");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset did not return the block to idle");

    // A load item with no pending result must not create one.
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_action && !o_out_valid) |=> !o_out_valid)
        else $error("load item produced a result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_result_value) && $stable(o_final_result)))
        else $error("stalled result changed or vanished");

endmodule

bind fused_bias_activation_top fba_port_checker u_fba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_action       (i_action),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_value (o_result_value),
    .o_final_result (o_final_result)
);
